[hw/rtl/full_period_multiplier_check_defines.svh]
// assertion macros shared by the full-period multiplier check modules
`ifndef FULL_PERIOD_MULTIPLIER_CHECK_DEFINES_SVH
`define FULL_PERIOD_MULTIPLIER_CHECK_DEFINES_SVH

// clocked check, masked while reset is asserted
`define FPMC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define FPMC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fpmc_pkg.sv]
// shared constants and controller/datapath interface types
package fpmc_pkg;

	// default modulus width and modulus after reset
	localparam int MOD_BITS_DEF  = 15;
	localparam int MODULUS_RESET = 32749;

	// commands from controller to datapath
	typedef struct packed {
		logic start;        // load multiplier and modulus, x = a, steps = 1
		logic mul_init;     // clear accumulator, point at top multiplier bit
		logic mul_step;     // one shift-add-reduce step of a * x mod m
		logic load_result;  // capture result fields
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic invalid;         // multiplier zero or not below modulus
		logic x_is_one;        // product is back at one
		logic steps_at_limit;  // step count reached the modulus
		logic bit_last;        // current multiply step is the last one
	} sts_t;

endpackage

[hw/rtl/fpmc_datapath.sv]
// datapath: operand registers, serial modular multiplier, step counter, result registers
`include "full_period_multiplier_check_defines.svh"

module fpmc_datapath #(
	parameter int MOD_BITS = fpmc_pkg::MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fpmc_pkg::cmd_t      cmd,
	output fpmc_pkg::sts_t      sts,
	input  logic [MOD_BITS-1:0] multiplier,
	input  logic [MOD_BITS-1:0] modulus,
	output logic                is_full_period,
	output logic [MOD_BITS-1:0] order,
	output logic                no_return
);

	localparam int BIT_W = $clog2(MOD_BITS);

	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] m_q;
	logic [MOD_BITS-1:0] x_q;
	logic [MOD_BITS-1:0] r_q;
	logic [MOD_BITS-1:0] steps_q;
	logic [BIT_W-1:0]    bit_q;
	logic                res_full_q;
	logic [MOD_BITS-1:0] res_order_q;
	logic                res_noret_q;

	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   dbl_red;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   sum_red;
	logic [MOD_BITS-1:0] r_next;
	logic                fail;

	// one step of the interleaved multiply: r = 2r + a[bit] * x, reduced mod m
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum     = dbl_red + (a_q[bit_q] ? {1'b0, x_q} : '0);
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		r_next  = sum_red[MOD_BITS-1:0];
	end

	// status toward the controller
	assign sts.invalid        = (a_q == '0) || (a_q >= m_q);
	assign sts.x_is_one       = (x_q == MOD_BITS'(1));
	assign sts.steps_at_limit = (steps_q >= m_q);
	assign sts.bit_last       = (bit_q == '0);

	assign fail = sts.invalid || !sts.x_is_one;

	// operand, product and count registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q     <= multiplier;
			m_q     <= modulus;
			x_q     <= multiplier;
			steps_q <= MOD_BITS'(1);
		end
		if (cmd.mul_init) begin
			r_q   <= '0;
			bit_q <= BIT_W'(MOD_BITS - 1);
		end
		if (cmd.mul_step) begin
			r_q   <= r_next;
			bit_q <= bit_q - 1'b1;
			// last bit done: the new product replaces x
			if (sts.bit_last) begin
				x_q     <= r_next;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (cmd.load_result) begin
			res_noret_q <= fail;
			res_order_q <= fail ? '0 : steps_q;
			res_full_q  <= !fail && (steps_q == m_q - 1'b1);
		end
	end

	assign is_full_period = res_full_q;
	assign order          = res_order_q;
	assign no_return      = res_noret_q;

	`FPMC_ASSERT_CLK(a_mul_operands_reduced, cmd.mul_step |-> (x_q < m_q) && (r_q < m_q),
		"multiply step with an operand not below the modulus")
	`FPMC_ASSERT_CLK(a_steps_bounded, cmd.mul_step |-> (steps_q < m_q),
		"step count passed the modulus")
	`FPMC_ASSERT_CLK(a_start_loads_operands, cmd.start |=> (steps_q == MOD_BITS'(1)) && (x_q == a_q),
		"request did not load the first power and step count")

endmodule

[hw/rtl/fpmc_ctrl.sv]
// controller: sequences request intake, multiply iterations and result hand-off
`include "full_period_multiplier_check_defines.svh"

module fpmc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output fpmc_pkg::cmd_t cmd,
	input  fpmc_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   finish;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;
	assign finish    = sts.invalid || sts.x_is_one || sts.steps_at_limit;

	// commands decoded from the current state
	assign cmd.start       = s_tready && s_tvalid;
	assign cmd.mul_init    = (state_q == ST_CHECK) && !finish;
	assign cmd.mul_step    = (state_q == ST_MUL);
	assign cmd.load_result = (state_q == ST_DONE) && slot_free;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= finish ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					if (sts.bit_last) state_q <= ST_CHECK;
				end
				ST_DONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FPMC_ASSERT_CLK(a_accept_to_check, (s_tvalid && s_tready) |=> (state_q == ST_CHECK),
		"accepted request did not move to the check state")
	`FPMC_ASSERT_ALWAYS(a_load_only_when_free, cmd.load_result |-> slot_free,
		"result loaded over a waiting result")
	`FPMC_ASSERT_CLK(a_no_mul_when_done, cmd.mul_init |-> !sts.invalid && !sts.x_is_one,
		"multiply started on an invalid or finished item")

endmodule

[hw/rtl/full_period_multiplier_check.sv]
// top level: modulus register, controller and datapath of the full-period multiplier check
//
// channel  | dir | fields (lsb first)
// s_axis   | in  | tdata: multiplier[MOD_BITS-1:0], zero pad
// m_axis   | out | tdata: is_full_period, order[MOD_BITS-1:0], no_return, zero pad
// cfg      | in  | cfg_wr_data: modulus[MOD_BITS-1:0], written when cfg_wr_en
//
// each modular multiply takes one step per multiplier bit in the serial shift-add unit, then a check state;
// items whose product never returns to one run longest, until the step count reaches the modulus.
// an invalid multiplier goes from the check state to the done state without a multiply.
// a new request is taken while the previous result still waits on m_tready; the next
// result then stalls in the done state until that one is taken.
// reset sets the modulus to 32749 and empties the output register.
module full_period_multiplier_check #(
	parameter int MOD_BITS = fpmc_pkg::MOD_BITS_DEF,
	localparam int IN_W    = ((MOD_BITS + 7) / 8) * 8,
	localparam int OUT_W   = ((MOD_BITS + 2 + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [MOD_BITS-1:0] cfg_wr_data,   // modulus
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,       // multiplier, pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata        // is_full_period, order, no_return, pad
);

	logic [MOD_BITS-1:0] modulus_q;
	fpmc_pkg::cmd_t      cmd;
	fpmc_pkg::sts_t      sts;
	logic                is_full_period;
	logic [MOD_BITS-1:0] order;
	logic                no_return;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_BITS'(fpmc_pkg::MODULUS_RESET);
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
		end
	end

	fpmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	fpmc_datapath #(
		.MOD_BITS (MOD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.multiplier     (s_tdata[MOD_BITS-1:0]),
		.modulus        (modulus_q),
		.is_full_period (is_full_period),
		.order          (order),
		.no_return      (no_return)
	);

	// pack result fields
	assign m_tdata = OUT_W'({no_return, order, is_full_period});

endmodule
